FILE: hdl/grtg_pkg.sv
// Shared types, codes and constants of the gradient ramp texel generator.
`timescale 1ns / 1ps

package grtg_pkg;

  localparam int POS_W  = 9;
  localparam int COL_W  = 32;
  localparam int PROD_W = 17;
  localparam int ROOT_W = 29;
  localparam int QUOT_W = 9;
  localparam int STEP_W = 4;

  localparam logic              OP_WRITE_STOP = 1'b0;
  localparam logic              OP_TEXEL      = 1'b1;

  localparam logic              KIND_LINEAR   = 1'b0;
  localparam logic              KIND_RADIAL   = 1'b1;

  localparam int                CFG_IDX_W         = 1;
  localparam int                CFG_DATA_W        = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_KIND = 1'd1;
  localparam logic [CFG_DATA_W-1:0] STOP_COUNT_RESET = 4'd2;

  localparam logic [1:0]        CH_RED   = 2'd0;
  localparam logic [1:0]        CH_GREEN = 2'd1;
  localparam logic [1:0]        CH_BLUE  = 2'd2;
  localparam logic [1:0]        CH_ALPHA = 2'd3;

  // restoring divider: index of the last quotient step; nine quotient bits per division
  localparam logic [STEP_W-1:0] DIV_LAST = 4'd8;
  // radius scale: 256 * sqrt(d2) / 63 maps a distance of 31.5 texels (half the side) to 256
  localparam logic [POS_W-1:0]  RADIUS_DIVISOR = 9'd63;
  localparam logic [ROOT_W-1:0] SQRT_FIRST_BIT = 29'h1000_0000;
  localparam logic [6:0]        CENTRE_X2      = 7'd63;

  typedef struct packed {
    logic       operation;
    logic [2:0] stop_slot;
    logic [8:0] stop_position;
    logic [7:0] stop_red;
    logic [7:0] stop_green;
    logic [7:0] stop_blue;
    logic [7:0] stop_alpha;
    logic [7:0] texel_x;
    logic [5:0] texel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LIN_SCAN,
    ST_LIN_PICK,
    ST_R_DX,
    ST_R_DY,
    ST_R_D2,
    ST_SQRT,
    ST_DIV,
    ST_R_SEARCH,
    ST_R_LOW,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_SOLID,
    ST_DONE
  } state_t;

  function automatic logic [7:0] chan_sel(input logic [COL_W-1:0] colour,
                                          input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      CH_RED:   v = colour[31:24];
      CH_GREEN: v = colour[23:16];
      CH_BLUE:  v = colour[15:8];
      default:  v = colour[7:0];
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/gradient_ramp_texel_generator.sv
// Top level: colour stop table, sequencer and shared multiply/divide/root datapath.
// Stop write: no result. Linear texel: the stop scan, then either the colour of one stop
//   or four blends of a multiply pair and a 9-step divide.
// Radial texel: a 15-step square root and a 9-step divide come first.
// One texel at a time; a finished result waits in the output register while the next
//   transaction is taken. Synchronous active-low reset clears control and config only.
`timescale 1ns / 1ps

module gradient_ramp_texel_generator #(
  parameter int MAX_STOPS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  grtg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output grtg_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [grtg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grtg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_STOPS);

  // stop tables
  logic [grtg_pkg::POS_W-1:0] stop_pos_r [MAX_STOPS];
  logic [grtg_pkg::COL_W-1:0] stop_col_r [MAX_STOPS];

  logic [grtg_pkg::CFG_DATA_W-1:0] stop_count_r;
  logic                            kind_r;

  grtg_pkg::state_t state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  grtg_pkg::out_item_t         out_data_r, out_data_nxt;

  logic [7:0]                  x_r, x_nxt;
  logic [5:0]                  y_r, y_nxt;
  logic [IDX_W-1:0]            last_r, last_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [IDX_W-1:0]            hit_r, hit_nxt;
  logic [grtg_pkg::POS_W-1:0]  x1_r, x1_nxt;
  logic [grtg_pkg::POS_W-1:0]  hx1_r, hx1_nxt;
  logic [grtg_pkg::POS_W-1:0]  hx2_r, hx2_nxt;
  logic [grtg_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [grtg_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [grtg_pkg::ROOT_W-1:0] v_r, v_nxt;
  logic [grtg_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [grtg_pkg::ROOT_W-1:0] bit_r, bit_nxt;
  logic [grtg_pkg::PROD_W-1:0] rem_r, rem_nxt;
  logic [grtg_pkg::PROD_W-1:0] dsh_r, dsh_nxt;
  logic [grtg_pkg::QUOT_W-1:0] quot_r, quot_nxt;
  logic [grtg_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        root_div_r, root_div_nxt;
  logic [grtg_pkg::POS_W-1:0]  f_r, f_nxt;
  logic [grtg_pkg::POS_W-1:0]  pb_r, pb_nxt;
  logic [grtg_pkg::COL_W-1:0]  ca_r, ca_nxt;
  logic [grtg_pkg::COL_W-1:0]  cb_r, cb_nxt;
  logic [grtg_pkg::POS_W-1:0]  wa_r, wa_nxt;
  logic [grtg_pkg::POS_W-1:0]  wb_r, wb_nxt;
  logic [grtg_pkg::POS_W-1:0]  den_r, den_nxt;
  logic [1:0]                  ch_r, ch_nxt;
  logic [grtg_pkg::COL_W-1:0]  res_r, res_nxt;

  logic                        in_accept;
  logic [grtg_pkg::POS_W-1:0]  rd_pos;
  logic [grtg_pkg::COL_W-1:0]  rd_col;
  logic [4:0]                  cnt_ext;
  logic [IDX_W-1:0]            last_calc;
  logic [7:0]                  mul_a;
  logic [grtg_pkg::POS_W-1:0]  mul_b;
  logic [6:0]                  two_x, two_y;
  logic [5:0]                  dx_mag, dy_mag;
  logic [grtg_pkg::POS_W-1:0]  x9;
  logic [grtg_pkg::ROOT_W:0]   sq_trial;
  logic                        div_ge;

  assign in_stall  = (state_r != grtg_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_pos = stop_pos_r[idx_r];
  assign rd_col = stop_col_r[idx_r];
  assign x9     = {1'b0, x_r};

  // stops in use, less one, with zero taken as one and saturation at the table size
  assign cnt_ext = {1'b0, stop_count_r};
  always_comb begin
    if (stop_count_r == '0) begin
      last_calc = '0;
    end else if (cnt_ext > 5'(MAX_STOPS)) begin
      last_calc = IDX_W'(MAX_STOPS - 1);
    end else begin
      last_calc = IDX_W'(cnt_ext - 5'd1);
    end
  end

  // distance from the centre, doubled: |2x - 63|
  assign two_x  = {x_r[5:0], 1'b0};
  assign two_y  = {y_r, 1'b0};
  assign dx_mag = (two_x >= grtg_pkg::CENTRE_X2) ? 6'(two_x - grtg_pkg::CENTRE_X2)
                                                 : 6'(grtg_pkg::CENTRE_X2 - two_x);
  assign dy_mag = (two_y >= grtg_pkg::CENTRE_X2) ? 6'(two_y - grtg_pkg::CENTRE_X2)
                                                 : 6'(grtg_pkg::CENTRE_X2 - two_y);

  // shared multiplier operands
  always_comb begin
    case (state_r)
      grtg_pkg::ST_R_DX: begin
        mul_a = 8'(dx_mag);
        mul_b = 9'(dx_mag);
      end
      grtg_pkg::ST_R_DY: begin
        mul_a = 8'(dy_mag);
        mul_b = 9'(dy_mag);
      end
      grtg_pkg::ST_MUL_A: begin
        mul_a = grtg_pkg::chan_sel(ca_r, ch_r);
        mul_b = wa_r;
      end
      grtg_pkg::ST_MUL_B: begin
        mul_a = grtg_pkg::chan_sel(cb_r, ch_r);
        mul_b = wb_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_trial = {1'b0, root_r} + {1'b0, bit_r};
  assign div_ge   = (rem_r >= dsh_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    x1_nxt        = x1_r;
    hx1_nxt       = hx1_r;
    hx2_nxt       = hx2_r;
    prod_nxt      = grtg_pkg::PROD_W'(mul_a) * grtg_pkg::PROD_W'(mul_b);
    acc_nxt       = acc_r;
    v_nxt         = v_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    root_div_nxt  = root_div_r;
    f_nxt         = f_r;
    pb_nxt        = pb_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    den_nxt       = den_r;
    ch_nxt        = ch_r;
    res_nxt       = res_r;

    case (state_r)
      grtg_pkg::ST_IDLE: begin
        if (in_accept && in_data.operation == grtg_pkg::OP_TEXEL) begin
          x_nxt    = in_data.texel_x;
          y_nxt    = in_data.texel_y;
          last_nxt = last_calc;
          if (kind_r == grtg_pkg::KIND_RADIAL) begin
            state_nxt = grtg_pkg::ST_R_DX;
          end else if (last_calc == '0) begin
            idx_nxt   = '0;
            state_nxt = grtg_pkg::ST_SOLID;
          end else begin
            idx_nxt   = IDX_W'(1);
            x1_nxt    = '0;
            hit_nxt   = '0;
            state_nxt = grtg_pkg::ST_LIN_SCAN;
          end
        end
      end

      // one segment per cycle; the last covering segment wins
      grtg_pkg::ST_LIN_SCAN: begin
        if (x9 >= x1_r && x9 < rd_pos) begin
          hit_nxt = idx_r;
          hx1_nxt = x1_r;
          hx2_nxt = rd_pos;
        end
        x1_nxt = rd_pos;
        if (idx_r == last_r) begin
          state_nxt = grtg_pkg::ST_LIN_PICK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      grtg_pkg::ST_LIN_PICK: begin
        if (hit_r == '0) begin
          // texel outside every segment: colour of the last stop
          idx_nxt   = last_r;
          state_nxt = grtg_pkg::ST_SOLID;
        end else begin
          wa_nxt    = hx2_r - x9;
          wb_nxt    = x9 - hx1_r;
          den_nxt   = hx2_r - hx1_r;
          idx_nxt   = hit_r - 1'b1;
          state_nxt = grtg_pkg::ST_FETCH_A;
        end
      end

      grtg_pkg::ST_FETCH_A: begin
        ca_nxt    = rd_col;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = grtg_pkg::ST_FETCH_B;
      end

      grtg_pkg::ST_FETCH_B: begin
        cb_nxt    = rd_col;
        ch_nxt    = grtg_pkg::CH_RED;
        state_nxt = grtg_pkg::ST_MUL_A;
      end

      grtg_pkg::ST_MUL_A: begin
        state_nxt = grtg_pkg::ST_MUL_B;
      end

      grtg_pkg::ST_MUL_B: begin
        acc_nxt   = prod_r;
        state_nxt = grtg_pkg::ST_SUM;
      end

      grtg_pkg::ST_SUM: begin
        rem_nxt      = grtg_pkg::PROD_W'({1'b0, acc_r} + {1'b0, prod_r});
        dsh_nxt      = {den_r, 8'b0};
        quot_nxt     = '0;
        step_nxt     = '0;
        root_div_nxt = 1'b0;
        state_nxt    = grtg_pkg::ST_DIV;
      end

      grtg_pkg::ST_R_DX: begin
        state_nxt = grtg_pkg::ST_R_DY;
      end

      grtg_pkg::ST_R_DY: begin
        acc_nxt   = prod_r;
        state_nxt = grtg_pkg::ST_R_D2;
      end

      grtg_pkg::ST_R_D2: begin
        v_nxt     = {13'(acc_r + prod_r), 16'b0};
        root_nxt  = '0;
        bit_nxt   = grtg_pkg::SQRT_FIRST_BIT;
        state_nxt = grtg_pkg::ST_SQRT;
      end

      // digit-by-digit square root, one result bit per cycle
      grtg_pkg::ST_SQRT: begin
        if ({1'b0, v_r} >= sq_trial) begin
          v_nxt    = v_r - grtg_pkg::ROOT_W'(sq_trial);
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == grtg_pkg::ROOT_W'(1)) begin
          rem_nxt      = grtg_pkg::PROD_W'(root_nxt);
          dsh_nxt      = {grtg_pkg::RADIUS_DIVISOR, 8'b0};
          quot_nxt     = '0;
          step_nxt     = '0;
          root_div_nxt = 1'b1;
          state_nxt    = grtg_pkg::ST_DIV;
        end
      end

      // restoring divide, one quotient bit per cycle
      grtg_pkg::ST_DIV: begin
        if (div_ge) begin
          rem_nxt = rem_r - dsh_r;
        end
        quot_nxt = {quot_r[grtg_pkg::QUOT_W-2:0], div_ge};
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r + 1'b1;
        if (step_r == grtg_pkg::DIV_LAST) begin
          if (root_div_r) begin
            f_nxt = quot_nxt;
            if (last_r == '0) begin
              idx_nxt   = '0;
              state_nxt = grtg_pkg::ST_SOLID;
            end else begin
              idx_nxt   = IDX_W'(1);
              state_nxt = grtg_pkg::ST_R_SEARCH;
            end
          end else begin
            res_nxt = {res_r[23:0], quot_nxt[7:0]};
            if (ch_r == grtg_pkg::CH_ALPHA) begin
              state_nxt = grtg_pkg::ST_DONE;
            end else begin
              ch_nxt    = ch_r + 1'b1;
              state_nxt = grtg_pkg::ST_MUL_A;
            end
          end
        end
      end

      // idx points at the upper stop of the bracket under test
      grtg_pkg::ST_R_SEARCH: begin
        if (idx_r < last_r && rd_pos < f_r) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          pb_nxt    = rd_pos;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = grtg_pkg::ST_R_LOW;
        end
      end

      grtg_pkg::ST_R_LOW: begin
        if (f_r <= rd_pos) begin
          state_nxt = grtg_pkg::ST_SOLID;
        end else if (f_r >= pb_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = grtg_pkg::ST_SOLID;
        end else begin
          ca_nxt    = rd_col;
          wa_nxt    = pb_r - f_r;
          wb_nxt    = f_r - rd_pos;
          den_nxt   = pb_r - rd_pos;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = grtg_pkg::ST_FETCH_B;
        end
      end

      grtg_pkg::ST_SOLID: begin
        res_nxt   = rd_col;
        state_nxt = grtg_pkg::ST_DONE;
      end

      grtg_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = grtg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = grtg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= grtg_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      stop_count_r <= grtg_pkg::STOP_COUNT_RESET;
      kind_r       <= grtg_pkg::KIND_LINEAR;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          grtg_pkg::CFG_STOP_COUNT:    stop_count_r <= cfg_wdata;
          grtg_pkg::CFG_GRADIENT_KIND: kind_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    x1_r       <= x1_nxt;
    hx1_r      <= hx1_nxt;
    hx2_r      <= hx2_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    v_r        <= v_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    quot_r     <= quot_nxt;
    step_r     <= step_nxt;
    root_div_r <= root_div_nxt;
    f_r        <= f_nxt;
    pb_r       <= pb_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    den_r      <= den_nxt;
    ch_r       <= ch_nxt;
    res_r      <= res_nxt;
  end

  // stop writes; slots past the table are dropped
  always_ff @(posedge clk) begin
    if (in_accept && in_data.operation == grtg_pkg::OP_WRITE_STOP &&
        32'(in_data.stop_slot) < MAX_STOPS) begin
      stop_pos_r[IDX_W'(in_data.stop_slot)] <= in_data.stop_position;
      stop_col_r[IDX_W'(in_data.stop_slot)] <= {in_data.stop_red, in_data.stop_green,
                                                in_data.stop_blue, in_data.stop_alpha};
    end
  end

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.operation == grtg_pkg::OP_WRITE_STOP)
      |=> state_r == grtg_pkg::ST_IDLE)
    else $error("stop write left the idle state");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grtg_pkg::ST_DIV && step_r == '0) |-> ({1'b0, rem_r} < {dsh_r, 1'b0}))
    else $error("dividend too large for the quotient width");

  a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == grtg_pkg::ST_SQRT |-> $onehot(bit_r))
    else $error("square root bit lost its single set bit");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == grtg_pkg::ST_R_SEARCH |-> (idx_r != '0 && idx_r <= last_r))
    else $error("radial search index outside the stops in use");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grtg_pkg::ST_DONE && out_valid_r && out_stall)
      |=> state_r == grtg_pkg::ST_DONE)
    else $error("finished texel dropped while the output was stalled");

endmodule

FILE: dv/gradient_ramp_texel_generator_tb.sv
// Self-checking bench for the gradient texel generator: stop writes, linear and radial texels.
`timescale 1ns / 1ps

module gradient_ramp_texel_generator_tb;

  localparam int STOPS         = 8;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 1000;
  localparam int PHASE_ITEMS   = 84;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  grtg_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  grtg_pkg::out_item_t             out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [grtg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [grtg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // bench copy of the stop table and registers
  logic [grtg_pkg::POS_W-1:0]      ramp_pos [STOPS];
  logic [grtg_pkg::COL_W-1:0]      ramp_col [STOPS];
  logic [grtg_pkg::CFG_DATA_W-1:0] stop_count_reg    = grtg_pkg::STOP_COUNT_RESET;
  logic                            gradient_kind_reg = grtg_pkg::KIND_LINEAR;

  grtg_pkg::out_item_t pending_texels [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic        hold_start     = 1'b0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned texels_checked = 0;
  int unsigned texels_sent    = 0;
  int unsigned stops_written  = 0;

  always #5 clk = ~clk;

  gradient_ramp_texel_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int unsigned live_stops();
    if (stop_count_reg == 0) return 1;
    if (stop_count_reg > STOPS) return STOPS;
    return 32'(stop_count_reg);
  endfunction

  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic grtg_pkg::out_item_t blend_texel(input logic [grtg_pkg::COL_W-1:0] ca, cb,
                                                      input int unsigned wa, wb, den);
    logic [grtg_pkg::COL_W-1:0] mixed;
    int unsigned                v;
    for (int c = 0; c < 4; c++) begin
      v = (32'(ca[8*c +: 8]) * wa + 32'(cb[8*c +: 8]) * wb) / den;
      mixed[8*c +: 8] = v[7:0];
    end
    return grtg_pkg::out_item_t'(mixed);
  endfunction

  function automatic grtg_pkg::out_item_t predict_texel(input grtg_pkg::in_item_t item);
    int unsigned n, x, lo, seg, seg_lo, seg_hi, d2, f, i;
    int          dx, dy;
    n = live_stops();
    if (gradient_kind_reg == grtg_pkg::KIND_LINEAR) begin
      x = 32'(item.texel_x);
      lo = 0;
      seg = 0;
      seg_lo = 0;
      seg_hi = 0;
      // later segments win where stops overlap
      for (int unsigned k = 1; k < n; k++) begin
        if (x >= lo && x < 32'(ramp_pos[k])) begin
          seg = k;
          seg_lo = lo;
          seg_hi = 32'(ramp_pos[k]);
        end
        lo = 32'(ramp_pos[k]);
      end
      if (seg == 0) return grtg_pkg::out_item_t'(ramp_col[n-1]);
      return blend_texel(ramp_col[seg-1], ramp_col[seg], seg_hi - x, x - seg_lo,
                         seg_hi - seg_lo);
    end
    if (n == 1) return grtg_pkg::out_item_t'(ramp_col[0]);
    // distance in 1/256 of 31.5 texels (half the side), column and row wrap at 64
    dx = 2 * int'(item.texel_x[5:0]) - 63;
    dy = 2 * int'(item.texel_y) - 63;
    d2 = dx * dx + dy * dy;
    f = root_floor(d2 << 16) / 63;
    i = 0;
    while (i < n - 2 && 32'(ramp_pos[i+1]) < f) i++;
    if (f <= 32'(ramp_pos[i])) return grtg_pkg::out_item_t'(ramp_col[i]);
    if (f >= 32'(ramp_pos[i+1])) return grtg_pkg::out_item_t'(ramp_col[i+1]);
    return blend_texel(ramp_col[i], ramp_col[i+1], 32'(ramp_pos[i+1]) - f,
                       f - 32'(ramp_pos[i]), 32'(ramp_pos[i+1]) - 32'(ramp_pos[i]));
  endfunction

  function automatic grtg_pkg::in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return grtg_pkg::in_item_t'(raw[$bits(grtg_pkg::in_item_t)-1:0]);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // one transaction on the input side; the table copy and the expectations follow acceptance
  task automatic offer_item(input grtg_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (item.operation == grtg_pkg::OP_TEXEL) begin
      pending_texels.push_back(predict_texel(item));
      texels_sent++;
    end else begin
      ramp_pos[item.stop_slot] = item.stop_position;
      ramp_col[item.stop_slot] = {item.stop_red, item.stop_green, item.stop_blue,
                                  item.stop_alpha};
      stops_written++;
    end
  endtask

  task automatic write_stop(input int unsigned slot, input int unsigned position,
                            input logic [grtg_pkg::COL_W-1:0] colour);
    grtg_pkg::in_item_t item;
    item = random_item();
    item.operation = grtg_pkg::OP_WRITE_STOP;
    item.stop_slot = 3'(slot);
    item.stop_position = 9'(position);
    {item.stop_red, item.stop_green, item.stop_blue, item.stop_alpha} = colour;
    offer_item(item);
  endtask

  task automatic request_texel(input int unsigned x, input int unsigned y);
    grtg_pkg::in_item_t item;
    item = random_item();
    item.operation = grtg_pkg::OP_TEXEL;
    item.texel_x = 8'(x);
    item.texel_y = 6'(y);
    offer_item(item);
  endtask

  // block idle: every texel back, plus margin for anything still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [grtg_pkg::CFG_IDX_W-1:0] idx,
                         input logic [grtg_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == grtg_pkg::CFG_STOP_COUNT) stop_count_reg = value;
    else gradient_kind_reg = value[0];
  endtask

  // ascending stop positions with random colours
  task automatic load_ramp(input bit pin_ends);
    int unsigned marks [$];
    for (int s = 0; s < STOPS; s++) marks.push_back($urandom_range(256));
    marks.sort();
    if (pin_ends) begin
      marks[0] = 0;
      marks[STOPS-1] = 256;
    end
    for (int s = 0; s < STOPS; s++) write_stop(s, marks[s], $urandom);
  endtask

  task automatic directed_linear_test();
    // every slot written first so no texel ever reads an empty stop
    write_stop(0, 0,   32'h0000_0000);
    write_stop(1, 40,  32'hFFFF_FFFF);
    write_stop(2, 90,  32'hFF00_FF00);
    write_stop(3, 128, 32'h00FF_00FF);
    write_stop(4, 128, 32'h1234_5678);
    write_stop(5, 200, 32'h8080_8080);
    write_stop(6, 256, 32'hFEDC_BA98);
    write_stop(7, 511, 32'h0F0F_0F0F);
    // two stops after reset: 255 lies past the last one
    request_texel(0, 0);
    request_texel(39, 0);
    request_texel(255, 63);
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd8);
    request_texel(0, 0);
    request_texel(128, 0);
    request_texel(255, 0);
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd6);
    request_texel(230, 0);
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd1);
    request_texel(100, 0);
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd0);
    request_texel(7, 0);
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd15);
    request_texel(250, 0);
  endtask

  task automatic directed_radial_test();
    settle();
    set_reg(grtg_pkg::CFG_GRADIENT_KIND, grtg_pkg::CFG_DATA_W'(grtg_pkg::KIND_RADIAL));
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd8);
    request_texel(0, 0);
    request_texel(31, 31);
    request_texel(63, 63);
    request_texel(255, 0);
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd1);
    request_texel(10, 50);
  endtask

  task automatic hold_off_test();
    grtg_pkg::in_item_t item;
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, 4'd8);
    set_reg(grtg_pkg::CFG_GRADIENT_KIND, grtg_pkg::CFG_DATA_W'(grtg_pkg::KIND_LINEAR));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_ramp(1'b1);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    // keep offering while results are held back so the input side backs up
    for (int k = 0; k < 24; k++) begin
      item = random_item();
      item.operation = grtg_pkg::OP_TEXEL;
      offer_item(item);
    end
  endtask

  task automatic random_phase_test(input logic [grtg_pkg::CFG_DATA_W-1:0] count,
                                   input logic kind,
                                   input int unsigned idle_pct, stall_pct);
    grtg_pkg::in_item_t item;
    settle();
    set_reg(grtg_pkg::CFG_STOP_COUNT, count);
    set_reg(grtg_pkg::CFG_GRADIENT_KIND, grtg_pkg::CFG_DATA_W'(kind));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_ramp($urandom_range(1));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      item = random_item();
      if ($urandom_range(99) < 12) begin
        item.operation = grtg_pkg::OP_WRITE_STOP;
        // mostly inside the ramp; the rest any 9-bit position, order broken
        if ($urandom_range(3) != 0) item.stop_position = 9'($urandom_range(256));
      end else begin
        item.operation = grtg_pkg::OP_TEXEL;
      end
      offer_item(item);
    end
  endtask

  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : texel_check
    grtg_pkg::out_item_t want;
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_texels.size() == 0) begin
        flag_error($sformatf("texel %h with none expected", out_data));
      end else begin
        want = pending_texels.pop_front();
        texels_checked++;
        if (out_data.out_red !== want.out_red)
          flag_error($sformatf("out_red exp %h got %h", want.out_red, out_data.out_red));
        if (out_data.out_green !== want.out_green)
          flag_error($sformatf("out_green exp %h got %h", want.out_green,
                               out_data.out_green));
        if (out_data.out_blue !== want.out_blue)
          flag_error($sformatf("out_blue exp %h got %h", want.out_blue, out_data.out_blue));
        if (out_data.out_alpha !== want.out_alpha)
          flag_error($sformatf("out_alpha exp %h got %h", want.out_alpha,
                               out_data.out_alpha));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d texels outstanding", cycle_count,
               pending_texels.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_linear_test();
    directed_radial_test();
    hold_off_test();
    random_phase_test(4'd2,  grtg_pkg::KIND_LINEAR, 0,  0);
    random_phase_test(4'd8,  grtg_pkg::KIND_RADIAL, 60, 0);
    random_phase_test(4'd1,  grtg_pkg::KIND_LINEAR, 0,  60);
    random_phase_test(4'd5,  grtg_pkg::KIND_RADIAL, 35, 35);
    random_phase_test(4'd0,  grtg_pkg::KIND_RADIAL, 0,  0);
    random_phase_test(4'd8,  grtg_pkg::KIND_LINEAR, 60, 0);
    random_phase_test(4'd3,  grtg_pkg::KIND_RADIAL, 0,  60);
    random_phase_test(4'd15, grtg_pkg::KIND_LINEAR, 35, 35);
    random_phase_test(4'd7,  grtg_pkg::KIND_LINEAR, 0,  0);
    random_phase_test(4'd8,  grtg_pkg::KIND_RADIAL, 60, 0);
    random_phase_test(4'd4,  grtg_pkg::KIND_LINEAR, 0,  60);
    random_phase_test(4'd9,  grtg_pkg::KIND_RADIAL, 35, 35);
    settle();
    $display("%0d of %0d texels checked, %0d stop writes; linear and radial, stop counts 0..15",
             texels_checked, texels_sent, stops_written);
    $display("idle mixes none/sender/receiver/both plus a %0d-cycle result hold-off; %0d errors",
             HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
